// File: hw/rtl/pcci_pkg.sv
package pcci_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_SAMPLE_PERIOD = 3'd2,
    REG_OUT_MIN       = 3'd3,
    REG_OUT_MAX       = 3'd4,
    REG_INTEG_MIN     = 3'd5,
    REG_INTEG_MAX     = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SAT_NONE = 2'd0,
    SAT_HIGH = 2'd1,
    SAT_LOW  = 2'd2
  } sat_code_t;

  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_A,
    ST_MUL_D,
    ST_INTEG,
    ST_OUTP
  } state_t;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain;
    logic        [31:0] sample_period;
    logic signed [31:0] out_min;
    logic signed [31:0] out_max;
    logic signed [31:0] integ_min;
    logic signed [31:0] integ_max;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = 42'sd2147483647;
    lo = -42'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: hw/rtl/pcci_cfg_regs.sv
module pcci_cfg_regs
  import pcci_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output cfg_t               cfg_o
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= '0;
      cfg_r.integ_gain    <= '0;
      cfg_r.sample_period <= '0;
      cfg_r.out_min       <= 32'sh80000000;
      cfg_r.out_max       <= 32'sh7FFFFFFF;
      cfg_r.integ_min     <= 32'sh80000000;
      cfg_r.integ_max     <= 32'sh7FFFFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     cfg_r.prop_gain     <= cfg_data;
        REG_INTEG_GAIN:    cfg_r.integ_gain    <= cfg_data;
        REG_SAMPLE_PERIOD: cfg_r.sample_period <= cfg_data;
        REG_OUT_MIN:       cfg_r.out_min       <= cfg_data;
        REG_OUT_MAX:       cfg_r.out_max       <= cfg_data;
        REG_INTEG_MIN:     cfg_r.integ_min     <= cfg_data;
        REG_INTEG_MAX:     cfg_r.integ_max     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/pcci_mul.sv
module pcci_mul
  import pcci_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic signed [65:0] prod
);

  logic signed [65:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

// File: hw/rtl/pi_controller_clamped_integrator.sv
// PI controller with a clamped integrator, signed Q16.16 data and Q8.24 gains.
// A step word is taken when the block is idle; its result is loaded into the
// output register from ST_OUTP, and the next word can be taken once the block
// is back in ST_IDLE. A clear word leaves the block idle and gives no result.
// A step runs through three passes of the one shared 33 by 33 bit multiplier
// (proportional term, integral term, scaling by the sample period) followed
// by the integrator clamp and the output clamp. A finished result waits in the
// output register while the next word is accepted; if it has still not been
// taken when the next result is ready, the block holds until it is.
module pi_controller_clamped_integrator
  import pcci_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_error_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive,
  output logic [1:0]         out_sat,
  output logic               out_integ_clamped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t               cfg;
  state_t             state_r, state_nxt;
  logic signed [31:0] err_r;
  logic signed [31:0] p_r;
  logic signed [31:0] integ_r, integ_nxt;
  logic               iclamp_r, iclamp_nxt;
  logic               out_valid_r;
  logic signed [31:0] drive_r, drive_nxt;
  logic [1:0]         sat_r, sat_nxt;
  logic               oclamp_r;
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  logic signed [31:0] a_val, d_val;
  logic signed [32:0] cand, sum;
  logic               accept, load_out;

  pcci_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  pcci_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign a_val    = sat32(prod[65:24]);
  assign d_val    = prod[63:32];
  assign cand     = {integ_r[31], integ_r} + {d_val[31], d_val};
  assign sum      = {p_r[31], p_r} + {integ_r[31], integ_r};
  assign load_out = (state_r == ST_OUTP) && (!out_valid_r || !out_stall);

  always_comb begin
    op_a = {cfg.prop_gain[31], cfg.prop_gain};
    op_b = {err_r[31], err_r};
    unique case (state_r)
      ST_MUL_A: op_a = {cfg.integ_gain[31], cfg.integ_gain};
      ST_MUL_D: begin
        op_a = {a_val[31], a_val};
        op_b = {1'b0, cfg.sample_period};
      end
      default: ;
    endcase
  end

  always_comb begin
    integ_nxt  = integ_r;
    iclamp_nxt = iclamp_r;
    if (cand > $signed({cfg.integ_max[31], cfg.integ_max}) && !err_r[31]) begin
      integ_nxt  = cfg.integ_max;
      iclamp_nxt = 1'b1;
    end else if (cand < $signed({cfg.integ_min[31], cfg.integ_min}) && err_r[31]) begin
      integ_nxt  = cfg.integ_min;
      iclamp_nxt = 1'b1;
    end else begin
      integ_nxt  = sat32({{9{cand[32]}}, cand});
      iclamp_nxt = 1'b0;
    end
  end

  always_comb begin
    if (sum >= $signed({cfg.out_max[31], cfg.out_max})) begin
      drive_nxt = cfg.out_max;
      sat_nxt   = SAT_HIGH;
    end else if (sum <= $signed({cfg.out_min[31], cfg.out_min})) begin
      drive_nxt = cfg.out_min;
      sat_nxt   = SAT_LOW;
    end else begin
      drive_nxt = sum[31:0];
      sat_nxt   = SAT_NONE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_req_type == REQ_STEP) begin
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: state_nxt = ST_MUL_A;
      ST_MUL_A: state_nxt = ST_MUL_D;
      ST_MUL_D: state_nxt = ST_INTEG;
      ST_INTEG: state_nxt = ST_OUTP;
      ST_OUTP: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_req_type == REQ_CLEAR) begin
        integ_r <= '0;
      end else if (state_r == ST_INTEG) begin
        integ_r <= integ_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r <= in_error_in;
    end
    if (state_r == ST_MUL_A) begin
      p_r <= sat32(prod[65:24]);
    end
    if (state_r == ST_INTEG) begin
      iclamp_r <= iclamp_nxt;
    end
    if (load_out) begin
      drive_r  <= drive_nxt;
      sat_r    <= sat_nxt;
      oclamp_r <= iclamp_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive         = drive_r;
  assign out_sat           = sat_r;
  assign out_integ_clamped = oclamp_r;

endmodule
